>>> src/icv_pkg.sv
// ----------------------------------------------------------------------------
// Image convolution package
// Shared constants, field widths, payload structs, register and state codes
// for the streaming 3x3 image convolution block.
// ----------------------------------------------------------------------------
package icv_pkg;

    // Default geometry of the block.
    localparam int KERNEL_ROWS_DEF = 3;
    localparam int KERNEL_COLS_DEF = 3;
    localparam int MAX_COLS_DEF    = 1024;
    localparam int PIXEL_BITS_DEF  = 8;

    // Field and register widths.
    localparam int ROWS_W     = 12;
    localparam int COLS_W     = 11;
    localparam int SCALE_W    = 24;
    localparam int COEF_W     = 16;
    localparam int INDEX_W    = 4;
    localparam int PIX_IN_W   = 8;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 10;
    localparam int VALUE_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int STEP_W     = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [ROWS_W-1:0]         ROWS_RESET  = 12'd480;
    localparam logic [COLS_W-1:0]         COLS_RESET  = 11'd640;
    localparam logic signed [SCALE_W-1:0] SCALE_RESET = 24'sd65536;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_IMAGE_ROWS = 2'd0,
        REG_IMAGE_COLS = 2'd1,
        REG_SCALE      = 2'd2
    } icv_reg_t;

    // Input command codes.
    typedef enum logic {
        CMD_COEF  = 1'b0,
        CMD_PIXEL = 1'b1
    } icv_cmd_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_REDUCE,
        ST_SCALE,
        ST_ROUND,
        ST_OUT
    } icv_state_t;

    // Input transaction payload.
    typedef struct packed {
        icv_cmd_t                   command;
        logic [INDEX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic [PIX_IN_W-1:0]        pixel;
    } icv_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [OUT_ROW_W-1:0]       out_row;
        logic [OUT_COL_W-1:0]       out_col;
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
    } icv_out_t;

    // Control from the sequencer to the column cells.
    typedef struct packed {
        logic              coef_we;
        logic              shift_en;
        logic              mul_en;
        logic              mul_first;
        logic              acc_en;
        logic              red_en;
        logic [STEP_W-1:0] step;
    } icv_ctrl_t;

endpackage

>>> src/icv_linebuf.sv
// ----------------------------------------------------------------------------
// Line buffer memory
// Simple dual-address memory, one word per image column, holding the
// buffered rows side by side. Write and registered read.
// ----------------------------------------------------------------------------
module icv_linebuf
    import icv_pkg::*;
#(
    parameter int DEPTH = MAX_COLS_DEF,
    parameter int WIDTH = (KERNEL_ROWS_DEF - 1) * PIXEL_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array with a registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/icv_cell.sv
// ----------------------------------------------------------------------------
// Convolution column cell
// Holds one column of the sliding window and the matching kernel column.
// Hands its pixels to the left neighbor on each shift and its partial sum
// to the right neighbor during the reduction steps.
// ----------------------------------------------------------------------------
module icv_cell
    import icv_pkg::*;
#(
    parameter int KR      = KERNEL_ROWS_DEF,
    parameter int KC      = KERNEL_COLS_DEF,
    parameter int PB      = PIXEL_BITS_DEF,
    parameter int COL_POS = 0,
    parameter int SUM_W   = PB + 1 + COEF_W + $clog2(KR * KC)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  icv_ctrl_t                ctrl,
    input  logic [INDEX_W-1:0]       coef_index,
    input  logic signed [COEF_W-1:0] coef_value,
    input  logic [KR-1:0][PB-1:0]    col_in,
    output logic [KR-1:0][PB-1:0]    col_out,
    input  logic signed [SUM_W-1:0]  acc_in,
    output logic signed [SUM_W-1:0]  acc_out
);

    localparam int PROD_W = PB + 1 + COEF_W;

    logic [KR-1:0][PB-1:0]    pix_reg;
    logic signed [COEF_W-1:0] coef_reg [KR];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic [PB-1:0]            pix_sel;
    logic signed [COEF_W-1:0] coef_sel;

    // Window row a meets kernel row KR-1-a (point-flipped kernel).
    always_comb begin
        pix_sel  = '0;
        coef_sel = '0;
        for (int a = 0; a < KR; a++) begin
            if (ctrl.step == STEP_W'(a)) begin
                pix_sel  = pix_reg[a];
                coef_sel = coef_reg[KR-1-a];
            end
        end
    end

    // Window column and kernel column; both are cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg <= '0;
            for (int r = 0; r < KR; r++) begin
                coef_reg[r] <= '0;
            end
        end else begin
            if (ctrl.shift_en) begin
                pix_reg <= col_in;
            end
            if (ctrl.coef_we) begin
                for (int r = 0; r < KR; r++) begin
                    if (int'(coef_index) == r * KC + (KC - 1 - COL_POS)) begin
                        coef_reg[r] <= coef_value;
                    end
                end
            end
        end
    end

    // Multiply one row per step, accumulate one step behind, then join the
    // partial sum chain when the reduction reaches this cell.
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= $signed({1'b0, pix_sel}) * coef_sel;
            acc_reg  <= ctrl.mul_first ? '0 : acc_reg + SUM_W'(prod_reg);
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end else if (ctrl.red_en && ctrl.step == STEP_W'(COL_POS)) begin
            acc_reg <= acc_reg + acc_in;
        end
    end

    assign col_out = pix_reg;
    assign acc_out = acc_reg;

endmodule

>>> src/image_convolution_2d.sv
// ----------------------------------------------------------------------------
// Streaming 2-D image convolution
// Kernel loads and raster-order pixels in, interior convolution results out.
// ----------------------------------------------------------------------------
// Each input transaction either loads one kernel coefficient or delivers the
// next pixel of the frame in raster order. A pixel that does not complete an
// interior window is handled by reading the line buffer column, then writing
// it back and shifting the window. A pixel that completes an interior window
// then also runs through ST_MUL, ST_ACC, ST_REDUCE, ST_SCALE, ST_ROUND and
// ST_OUT, because each column cell has one multiplier that walks the kernel
// rows in turn, the partial sums then travel along the chain of cells one cell
// per cycle, and the scaling multiply and rounding are each registered before
// saturation feeds the output register. A result waiting in the output
// register does not hold up later pixels that produce no result. After reset
// the line buffers are cleared, one column per cycle, before the first
// transaction is taken; configuration writes are taken at any time.
module image_convolution_2d
    import icv_pkg::*;
#(
    parameter int KERNEL_ROWS = KERNEL_ROWS_DEF,
    parameter int KERNEL_COLS = KERNEL_COLS_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  icv_in_t               s_data,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output icv_out_t              m_data,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int KR       = KERNEL_ROWS;
    localparam int KC       = KERNEL_COLS;
    localparam int PB       = PIXEL_BITS;
    localparam int LB_ROWS  = (KR > 1) ? KR - 1 : 1;
    localparam int LB_W     = LB_ROWS * PB;
    localparam int ADDR_W   = $clog2(MAX_COLS);
    localparam int SUM_W    = PB + 1 + COEF_W + $clog2(KR * KC);
    localparam int PSCALE_W = SUM_W + SCALE_W;
    localparam int QUOT_W   = PSCALE_W - FRAC_BITS;
    localparam int SAT_W    = (QUOT_W > VALUE_W + 1) ? QUOT_W : VALUE_W + 1;

    localparam logic signed [SAT_W-1:0] VAL_MAX = SAT_W'(2147483647);
    localparam logic signed [SAT_W-1:0] VAL_MIN = SAT_W'(-2147483647 - 1);

    // Configuration registers
    logic [ROWS_W-1:0]         rows_reg;
    logic [COLS_W-1:0]         cols_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    logic                      cfg_we;
    icv_reg_t                  cfg_sel;

    // Sequencer
    icv_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    icv_ctrl_t         ctrl;

    // Frame position and per-pixel latches
    logic [ROWS_W-1:0]    row_count_reg, row_count_next;
    logic [COLS_W-1:0]    col_count_reg, col_count_next;
    logic [PB-1:0]        pix_reg;
    logic [ADDR_W-1:0]    lb_addr_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic                 last_reg;
    logic                 emit_reg;

    // Position arithmetic
    logic [ROWS_W-1:0] rows_eff;
    logic [COLS_W-1:0] cols_eff;
    logic              col_wrap;
    logic [ROWS_W-1:0] row_pre;
    logic [ROWS_W-1:0] cur_r;
    logic [COLS_W-1:0] cur_c;
    logic              frame_end;
    logic              emit;
    logic              pix_accept;

    // Line buffer
    logic                      lb_we;
    logic                      lb_re;
    logic [ADDR_W-1:0]         lb_waddr;
    logic [LB_ROWS-1:0][PB-1:0] lb_wword;
    logic [LB_ROWS-1:0][PB-1:0] lb_rword;
    logic [KR-1:0][PB-1:0]     new_col;

    // Cell chain
    logic [KR-1:0][PB-1:0]    cell_col [KC];
    logic [KR-1:0][PB-1:0]    cell_col_in [KC];
    logic signed [SUM_W-1:0]  cell_acc [KC];
    logic signed [SUM_W-1:0]  cell_acc_in [KC];

    // Scaling and output
    logic signed [PSCALE_W-1:0] scaled_reg;
    logic signed [PSCALE_W-1:0] biased;
    logic signed [QUOT_W-1:0]   quot_reg;
    logic signed [SAT_W-1:0]    quot_ext;
    logic signed [VALUE_W-1:0]  sat_value;
    logic                       out_load;
    logic                       m_valid_reg;
    icv_out_t                   m_data_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = icv_reg_t'(paddr[3:2]);

    // Register writes; a write to an unused address is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= ROWS_RESET;
            cols_reg  <= COLS_RESET;
            scale_reg <= SCALE_RESET;
        end else if (cfg_we) begin
            case (cfg_sel)
                REG_IMAGE_ROWS: rows_reg  <= pwdata[ROWS_W-1:0];
                REG_IMAGE_COLS: cols_reg  <= pwdata[COLS_W-1:0];
                REG_SCALE:      scale_reg <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_sel)
            REG_IMAGE_ROWS: prdata = APB_DATA_W'(rows_reg);
            REG_IMAGE_COLS: prdata = APB_DATA_W'(cols_reg);
            REG_SCALE:      prdata = APB_DATA_W'(scale_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame position of the incoming pixel
    // ------------------------------------------------------------------
    always_comb begin
        rows_eff = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
        if (cols_reg == '0) begin
            cols_eff = COLS_W'(1);
        end else if (int'(cols_reg) > MAX_COLS) begin
            cols_eff = COLS_W'(MAX_COLS);
        end else begin
            cols_eff = cols_reg;
        end

        // A column count at or past the width moves to the next row.
        col_wrap = (col_count_reg >= cols_eff);
        row_pre  = col_wrap ? row_count_reg + ROWS_W'(1) : row_count_reg;
        cur_r    = (row_pre >= rows_eff) ? '0 : row_pre;
        cur_c    = col_wrap ? '0 : col_count_reg;

        frame_end = (cur_r == rows_eff - ROWS_W'(1)) && (cur_c == cols_eff - COLS_W'(1));
        emit      = (int'(cur_r) >= KR - 1) && (int'(cur_c) >= KC - 1);

        row_count_next = frame_end ? '0 : cur_r;
        col_count_next = frame_end ? '0 : cur_c + COLS_W'(1);
    end

    assign pix_accept = s_valid && s_ready && (s_data.command == CMD_PIXEL);

    // Position counters; cleared by reset and wrapped at the frame end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else if (pix_accept) begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // Per-pixel values carried through the sequence.
    always_ff @(posedge aclk) begin
        if (pix_accept) begin
            pix_reg     <= PB'(s_data.pixel);
            lb_addr_reg <= ADDR_W'(cur_c);
            out_row_reg <= OUT_ROW_W'(int'(cur_r) + KR / 2 + 1 - KR);
            out_col_reg <= OUT_COL_W'(int'(cur_c) + KC / 2 + 1 - KC);
            last_reg    <= frame_end;
            emit_reg    <= emit;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            step_reg     <= '0;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Next state.
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MAX_COLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pix_accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                step_next  = '0;
                state_next = emit_reg ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                if (step_reg == STEP_W'(KR - 1)) begin
                    state_next = ST_ACC;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_ACC: begin
                step_next  = STEP_W'(1);
                state_next = (KC > 1) ? ST_REDUCE : ST_SCALE;
            end
            ST_REDUCE: begin
                if (step_reg == STEP_W'(KC - 1)) begin
                    state_next = ST_SCALE;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SCALE: state_next = ST_ROUND;
            ST_ROUND: state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready  = 1'b0;
        ctrl     = '0;
        lb_we    = 1'b0;
        lb_re    = 1'b0;
        lb_waddr = lb_addr_reg;
        out_load = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                lb_we    = 1'b1;
                lb_waddr = clr_addr_reg;
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                ctrl.coef_we = s_valid && (s_data.command == CMD_COEF);
                lb_re        = pix_accept;
            end
            ST_READ: begin
                ctrl.shift_en = 1'b1;
                lb_we         = 1'b1;
            end
            ST_MUL: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_first = (step_reg == '0);
                ctrl.step      = step_reg;
            end
            ST_ACC: begin
                ctrl.acc_en = 1'b1;
            end
            ST_REDUCE: begin
                ctrl.red_en = 1'b1;
                ctrl.step   = step_reg;
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Line buffer column update
    // ------------------------------------------------------------------
    // New window column: buffered rows on top, the new pixel at the bottom.
    // Each buffered row moves up by one; the clearing pass writes zeros.
    always_comb begin
        for (int a = 0; a < KR - 1; a++) begin
            new_col[a] = lb_rword[a];
        end
        new_col[KR-1] = pix_reg;
        for (int a = 0; a < LB_ROWS; a++) begin
            if (state_reg == ST_CLEAR) begin
                lb_wword[a] = '0;
            end else if (a + 1 < KR - 1) begin
                lb_wword[a] = lb_rword[(a + 1 < LB_ROWS) ? a + 1 : a];
            end else begin
                lb_wword[a] = pix_reg;
            end
        end
    end

    icv_linebuf #(
        .DEPTH (MAX_COLS),
        .WIDTH (LB_W)
    ) u_linebuf (
        .aclk  (aclk),
        .we    (lb_we),
        .waddr (lb_waddr),
        .wdata (lb_wword),
        .re    (lb_re),
        .raddr (ADDR_W'(cur_c)),
        .rdata (lb_rword)
    );

    // ------------------------------------------------------------------
    // Chain of column cells
    // ------------------------------------------------------------------
    for (genvar b = 0; b < KC; b++) begin : g_cell
        if (b == KC - 1) begin : g_head
            assign cell_col_in[b] = new_col;
        end else begin : g_body
            assign cell_col_in[b] = cell_col[b+1];
        end
        if (b == 0) begin : g_first
            assign cell_acc_in[b] = '0;
        end else begin : g_next
            assign cell_acc_in[b] = cell_acc[b-1];
        end

        icv_cell #(
            .KR      (KR),
            .KC      (KC),
            .PB      (PB),
            .COL_POS (b),
            .SUM_W   (SUM_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .coef_index (s_data.coef_index),
            .coef_value (s_data.coef_value),
            .col_in     (cell_col_in[b]),
            .col_out    (cell_col[b]),
            .acc_in     (cell_acc_in[b]),
            .acc_out    (cell_acc[b])
        );
    end

    // ------------------------------------------------------------------
    // Scaling, truncation toward zero and saturation
    // ------------------------------------------------------------------
    assign biased = scaled_reg + (scaled_reg[PSCALE_W-1] ?
                    PSCALE_W'((1 << FRAC_BITS) - 1) : PSCALE_W'(0));

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCALE) begin
            scaled_reg <= cell_acc[KC-1] * scale_reg;
        end
        if (state_reg == ST_ROUND) begin
            quot_reg <= QUOT_W'(biased >>> FRAC_BITS);
        end
    end

    always_comb begin
        quot_ext = SAT_W'(quot_reg);
        if (quot_ext > VAL_MAX) begin
            sat_value = VAL_MAX[VALUE_W-1:0];
        end else if (quot_ext < VAL_MIN) begin
            sat_value = VAL_MIN[VALUE_W-1:0];
        end else begin
            sat_value = quot_ext[VALUE_W-1:0];
        end
    end

    // Output register; a new result loads once the previous one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.out_row <= out_row_reg;
            m_data_reg.out_col <= out_col_reg;
            m_data_reg.value   <= sat_value;
            m_data_reg.last    <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the streaming 3x3 image convolution block
// Drives kernel loads and raster-order pixels through the input channel,
// reprograms frame size and scale over the register port between phases,
// and compares every result transaction against a cycle-free model of the
// line buffers, window and scaled, saturated window sum.
// ----------------------------------------------------------------------------
module tb;
    import icv_pkg::*;

    localparam int K_ROWS    = KERNEL_ROWS_DEF;
    localparam int K_COLS    = KERNEL_COLS_DEF;
    localparam int K_TAPS    = K_ROWS * K_COLS;
    localparam int LINE_LEN  = MAX_COLS_DEF;
    localparam int SETTLE    = 24;
    localparam int MAX_SHOWN = 10;

    // Expected-output tracker: keeps its own copy of the kernel, line buffers,
    // window, raster position and registers, and queues the expected results.
    class conv_scoreboard;
        logic signed [COEF_W-1:0]  taps [K_TAPS];
        logic [PIX_IN_W-1:0]       line_mem [K_ROWS-1][LINE_LEN];
        logic [PIX_IN_W-1:0]       win [K_ROWS][K_COLS];
        int unsigned               row_pos;
        int unsigned               col_pos;
        logic [ROWS_W-1:0]         img_rows;
        logic [COLS_W-1:0]         img_cols;
        logic signed [SCALE_W-1:0] scl;
        icv_out_t                  expected_pixels [$];
        int                        errors;

        function new();
            foreach (taps[i]) taps[i] = '0;
            foreach (line_mem[i, j]) line_mem[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            row_pos  = 0;
            col_pos  = 0;
            img_rows = ROWS_RESET;
            img_cols = COLS_RESET;
            scl      = SCALE_RESET;
            errors   = 0;
        endfunction

        function void set_reg(icv_reg_t idx, logic [APB_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_ROWS: img_rows = data[ROWS_W-1:0];
                REG_IMAGE_COLS: img_cols = data[COLS_W-1:0];
                REG_SCALE:      scl = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Apply one accepted input transaction and queue the result it causes.
        function void note_input(icv_in_t item);
            int unsigned          rows, cols, r, c;
            logic [PIX_IN_W-1:0]  column [K_ROWS];
            longint               acc;
            bit                   frame_end;
            icv_out_t             res;

            if (item.command == CMD_COEF) begin
                if (item.coef_index < K_TAPS) taps[item.coef_index] = item.coef_value;
                return;
            end

            // Zero sizes act as one; widths beyond the line buffer are clamped.
            rows = (img_rows == 0) ? 1 : img_rows;
            cols = (img_cols == 0) ? 1 : img_cols;
            if (cols > LINE_LEN) cols = LINE_LEN;
            if (col_pos >= cols) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= rows) row_pos = 0;
            r = row_pos;
            c = col_pos;

            // New window column: buffered rows on top, the new pixel at the bottom.
            for (int a = 0; a < K_ROWS - 1; a++) column[a] = line_mem[a][c];
            column[K_ROWS-1] = item.pixel;
            for (int a = 0; a < K_ROWS - 1; a++) line_mem[a][c] = column[a+1];
            for (int a = 0; a < K_ROWS; a++) begin
                for (int b = 0; b < K_COLS - 1; b++) win[a][b] = win[a][b+1];
                win[a][K_COLS-1] = column[a];
            end

            frame_end = (r == rows - 1) && (c == cols - 1);
            col_pos = (c + 1) & 32'h7FF;
            if (frame_end) begin
                col_pos = 0;
                row_pos = 0;
            end

            if (r + 1 >= K_ROWS && c + 1 >= K_COLS) begin
                // True convolution: the kernel is point-flipped against the window.
                acc = 0;
                for (int a = 0; a < K_ROWS; a++)
                    for (int b = 0; b < K_COLS; b++)
                        acc += longint'(win[a][b]) *
                               longint'(taps[(K_ROWS-1-a)*K_COLS + (K_COLS-1-b)]);
                acc = (acc * longint'(scl)) / 65536;
                if (acc > longint'(32'sh7FFF_FFFF)) acc = 32'sh7FFF_FFFF;
                if (acc < -longint'(64'sd2147483648)) acc = -longint'(64'sd2147483648);
                res.out_row = OUT_ROW_W'(r + 1 - K_ROWS + K_ROWS / 2);
                res.out_col = OUT_COL_W'(c + 1 - K_COLS + K_COLS / 2);
                res.value   = acc[VALUE_W-1:0];
                res.last    = frame_end;
                expected_pixels.push_back(res);
            end
        endfunction

        // Compare one result transaction against the oldest expectation.
        function void check_result(icv_out_t got);
            icv_out_t want;

            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("ERROR: unexpected result row %0d col %0d value %0d last %0d",
                             got.out_row, got.out_col, got.value, got.last);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                got.value !== want.value || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("ERROR: expected row %0d col %0d value %0d last %0d, %s",
                             want.out_row, want.out_col, want.value, want.last,
                             $sformatf("got row %0d col %0d value %0d last %0d",
                                       got.out_row, got.out_col, got.value, got.last));
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    icv_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    icv_out_t              m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    conv_scoreboard sb = new();
    int send_idle_pct = 9;
    int recv_idle_pct = 73;

    image_convolution_2d dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: check each accepted transaction, then pick the next ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Present one input transaction and wait until it is accepted.
    task automatic send_item(input icv_in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(item);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input icv_reg_t idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold off input until every result is out and the pipeline has gone quiet,
    // then program the frame size and scale.
    task automatic configure(input int unsigned rows, input int unsigned cols,
                             input logic signed [SCALE_W-1:0] scale_q);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        write_reg(REG_IMAGE_ROWS, APB_DATA_W'(rows));
        write_reg(REG_IMAGE_COLS, APB_DATA_W'(cols));
        write_reg(REG_SCALE, APB_DATA_W'(scale_q));
    endtask

    function automatic logic signed [SCALE_W-1:0] pick_scale();
        case ($urandom_range(4))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return SCALE_W'($urandom);
            3: return SCALE_W'(int'($urandom_range(262143)) - 131072);
            default: return -24'sd65536;
        endcase
    endfunction

    // Mostly pixels, with kernel reloads mixed in, some at ignored indexes.
    function automatic icv_in_t random_item();
        icv_in_t item;
        item.command    = ($urandom_range(99) < 10) ? CMD_COEF : CMD_PIXEL;
        item.coef_index = ($urandom_range(3) == 0) ? INDEX_W'($urandom_range(15))
                                                   : INDEX_W'($urandom_range(K_TAPS - 1));
        item.coef_value = COEF_W'($urandom);
        item.pixel      = PIX_IN_W'($urandom);
        return item;
    endfunction

    initial begin
        logic signed [COEF_W-1:0] kern_init [K_TAPS] = '{
            16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh7FFF,
            16'sh7FFF, 16'sh7FFF, 16'sh0001, 16'sh7FFF};
        logic [PIX_IN_W-1:0] pix_init [K_TAPS] = '{
            8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'hFF, 8'h7F, 8'hFF};
        int unsigned rows, cols, count;
        logic signed [SCALE_W-1:0] scale_q;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: smallest frame that yields a result, full kernel with
        // extreme coefficients, loads at ignored indexes, largest scale.
        configure(3, 3, 24'sh7FFFFF);
        for (int i = 0; i < K_TAPS; i++)
            send_item('{CMD_COEF, INDEX_W'(i), kern_init[i], 8'h5A});
        send_item('{CMD_COEF, 4'd9, 16'sh7FFF, 8'hFF});
        send_item('{CMD_COEF, 4'd15, 16'sh8000, 8'h00});
        for (int i = 0; i < K_TAPS; i++)
            send_item('{CMD_PIXEL, 4'hF, 16'shFFFF, pix_init[i]});

        // Random phases, each with its own frame size and scale.
        for (int p = 0; p < 12; p++) begin
            case (p / 4)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 73;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0: begin
                    rows = 4; cols = 5; scale_q = 24'sd65536; count = 80;
                end
                1: begin
                    // Zero sizes: a one-pixel frame, never any result.
                    rows = 0; cols = 0; scale_q = pick_scale(); count = 20;
                end
                2: begin
                    rows = 6; cols = 3; scale_q = 24'sh800000; count = 90;
                end
                3: begin
                    // Full line buffer width.
                    rows = 3; cols = 1024; scale_q = 24'sh7FFFFF; count = 50;
                end
                4: begin
                    // Width beyond the line buffer is clamped to it.
                    rows = 5; cols = 2047; scale_q = 24'sd0; count = 20;
                end
                5: begin
                    rows = 4095; cols = 4; scale_q = pick_scale(); count = 90;
                end
                default: begin
                    rows = $urandom_range(2, 8);
                    cols = $urandom_range(2, 12);
                    scale_q = pick_scale();
                    count = 90;
                end
            endcase
            // The raster position carries over, so shrinking sizes mid-frame wraps.
            configure(rows, cols, scale_q);
            for (int i = 0; i < count; i++) send_item(random_item());
        end

        // Let the last results drain before the verdict.
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("image_convolution_2d: match");
        end else begin
            $display("image_convolution_2d: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("image_convolution_2d: mismatch");
        $finish;
    end

endmodule

>>> files.f
src/icv_pkg.sv
src/icv_linebuf.sv
src/icv_cell.sv
src/image_convolution_2d.sv
tb/tb.sv
